>>> design/sfa_pkg.sv
// ----------------------------------------------------------------------------
// sfa_pkg
// shared types and codes of the smallest free id allocator
// ----------------------------------------------------------------------------
package sfa_pkg;

   // request command codes
   localparam logic CMD_POP = 1'b0;
   localparam logic CMD_ADD = 1'b1;

   // sequencer states, one-hot
   typedef enum logic [8:0] {
      ST_IDLE     = 9'b000000001,
      ST_ADD_CHK  = 9'b000000010,
      ST_SU_STEP  = 9'b000000100,
      ST_SU_CMP   = 9'b000001000,
      ST_POP_TOP  = 9'b000010000,
      ST_POP_LAST = 9'b000100000,
      ST_SD_STEP  = 9'b001000000,
      ST_SD_L     = 9'b010000000,
      ST_SD_R     = 9'b100000000
   } state_type;

endpackage

>>> design/sfa_ram.sv
// ----------------------------------------------------------------------------
// sfa_ram
// generic single write, single read memory with registered read data
// ----------------------------------------------------------------------------
module sfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/smallest_free_id_allocator.sv
// ----------------------------------------------------------------------------
// smallest_free_id_allocator
// hands out the smallest free number from 1 upward, takes numbers back
// ----------------------------------------------------------------------------
// usage
//   a request is taken on a clock edge where start is high and busy is low
//   req_cmd pop: the smallest free number comes out on rsp_smallest_value
//     with a one-cycle rsp_valid strobe; rsp_exhausted set (value 0) once
//     every number up to MAX_VALUE is out
//   req_cmd add: req_number goes back into the free pool if it was issued
//     and is not already free; no response
//   a pop served from the fresh counter answers the next cycle and busy
//     never rises; a pop from the returned-number heap reads the heap top,
//     registers its response in ST_POP_TOP and then stays busy for the sift down
//   an add-back that passes its check stays busy for the sift up
//   the cost per level is set by the single heap memory read port and the
//   one shared comparator, one read and one compare per cycle
//   reset: synchronous, brings back an empty heap and a counter of 1; the
//     memories are not swept, every entry is written before it is read
//   the receiver cannot stall: each response is shown for exactly one cycle
// ----------------------------------------------------------------------------
module smallest_free_id_allocator
   import sfa_pkg::*;
#(
   parameter int MAX_VALUE = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_cmd,
   input  logic [$clog2(MAX_VALUE+2)-1:0]     req_number,
   output logic                               rsp_valid,
   output logic [$clog2(MAX_VALUE+2)-1:0]     rsp_smallest_value,
   output logic                               rsp_exhausted
);

   // value width holds 0 .. MAX_VALUE + 1, heap index width holds 0 .. MAX_VALUE - 1
   localparam int VW  = $clog2(MAX_VALUE + 2);
   localparam int AW  = $clog2(MAX_VALUE);
   localparam int BAW = $clog2(MAX_VALUE + 1);
   localparam int CW  = AW + 2;
   localparam logic [VW-1:0] FRESH_END = VW'(MAX_VALUE + 1);

   state_type         state_ff, state_in;
   logic [VW-1:0]     count_ff, count_in;   // heap occupancy
   logic [VW-1:0]     fresh_ff, fresh_in;   // smallest never-issued number
   logic [VW-1:0]     num_ff, num_in;
   logic [VW-1:0]     cur_ff, cur_in;       // value looking for its slot
   logic [AW-1:0]     pos_ff, pos_in;       // hole position in the heap
   logic [VW-1:0]     bv_ff, bv_in;         // best of hole value and left child
   logic              move_ff, move_in;     // left child beat the hole value
   logic              rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0]     rsp_value_ff, rsp_value_in;
   logic              rsp_exh_ff, rsp_exh_in;

   // shared comparator
   logic [VW-1:0]     cmp_a, cmp_b;
   logic              cmp_lt;

   // heap memory ports
   logic              heap_we, heap_re;
   logic [AW-1:0]     heap_waddr, heap_raddr;
   logic [VW-1:0]     heap_wdata, heap_rdata;

   // presence map ports
   logic              map_we, map_re;
   logic [BAW-1:0]    map_waddr, map_raddr;
   logic              map_wdata, map_rdata;

   logic [AW-1:0]     parent;
   logic [CW-1:0]     l_idx, r_idx, count_ext;
   logic              l_ok, r_ok;
   logic [VW-1:0]     count_dec;
   logic              issue_fresh;

   sfa_ram #(.WIDTH(VW), .DEPTH(MAX_VALUE)) u_heap_ram (
      .clock   (clock),
      .wr_en   (heap_we),
      .wr_addr (heap_waddr),
      .wr_data (heap_wdata),
      .rd_en   (heap_re),
      .rd_addr (heap_raddr),
      .rd_data (heap_rdata)
   );

   // map entries above the fresh counter are never read; each is cleared as
   // its number is first issued
   sfa_ram #(.WIDTH(1), .DEPTH(MAX_VALUE + 1)) u_map_ram (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (map_waddr),
      .wr_data (map_wdata),
      .rd_en   (map_re),
      .rd_addr (map_raddr),
      .rd_data (map_rdata)
   );

   // heap index arithmetic
   assign parent    = (pos_ff - AW'(1)) >> 1;
   assign l_idx     = {1'b0, pos_ff, 1'b1};
   assign r_idx     = l_idx + CW'(1);
   assign count_ext = CW'(count_ff);
   assign l_ok      = l_idx < count_ext;
   assign r_ok      = r_idx < count_ext;
   assign count_dec = count_ff - VW'(1);

   // operand selection for the one comparator
   always_comb begin
      cmp_a = cur_ff;
      cmp_b = heap_rdata;
      case (state_ff)
         ST_IDLE: begin
            cmp_a = req_number;
            cmp_b = fresh_ff;
         end
         ST_POP_TOP: begin
            cmp_a = heap_rdata;
            cmp_b = fresh_ff;
         end
         ST_SU_CMP: begin
            cmp_a = cur_ff;
            cmp_b = heap_rdata;
         end
         ST_SD_L: begin
            cmp_a = heap_rdata;
            cmp_b = cur_ff;
         end
         ST_SD_R: begin
            cmp_a = heap_rdata;
            cmp_b = bv_ff;
         end
         default: begin
            cmp_a = cur_ff;
            cmp_b = heap_rdata;
         end
      endcase
   end

   assign cmp_lt = cmp_a < cmp_b;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      fresh_in     = fresh_ff;
      num_in       = num_ff;
      cur_in       = cur_ff;
      pos_in       = pos_ff;
      bv_in        = bv_ff;
      move_in      = move_ff;
      rsp_valid_in = 1'b0;
      rsp_value_in = rsp_value_ff;
      rsp_exh_in   = rsp_exh_ff;
      heap_we      = 1'b0;
      heap_waddr   = pos_ff;
      heap_wdata   = cur_ff;
      heap_re      = 1'b0;
      heap_raddr   = '0;
      map_we       = 1'b0;
      map_waddr    = fresh_ff[BAW-1:0];
      map_wdata    = 1'b0;
      map_re       = 1'b0;
      map_raddr    = req_number[BAW-1:0];
      issue_fresh  = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               num_in = req_number;
               if (req_cmd == CMD_ADD) begin
                  // only numbers already issued may come back
                  if (req_number != '0 && cmp_lt) begin
                     map_re   = 1'b1;
                     state_in = ST_ADD_CHK;
                  end
               end else if (count_ff != '0) begin
                  heap_re    = 1'b1;
                  heap_raddr = '0;
                  state_in   = ST_POP_TOP;
               end else begin
                  issue_fresh = 1'b1;
               end
            end
         end
         ST_ADD_CHK: begin
            if (map_rdata) begin
               state_in = ST_IDLE;
            end else begin
               map_we    = 1'b1;
               map_waddr = num_ff[BAW-1:0];
               map_wdata = 1'b1;
               count_in  = count_ff + VW'(1);
               cur_in    = num_ff;
               pos_in    = count_ff[AW-1:0];
               state_in  = ST_SU_STEP;
            end
         end
         ST_SU_STEP: begin
            if (pos_ff == '0) begin
               heap_we  = 1'b1;
               state_in = ST_IDLE;
            end else begin
               heap_re    = 1'b1;
               heap_raddr = parent;
               state_in   = ST_SU_CMP;
            end
         end
         ST_SU_CMP: begin
            heap_we = 1'b1;
            if (cmp_lt) begin
               // parent moves down into the hole
               heap_wdata = heap_rdata;
               pos_in     = parent;
               state_in   = ST_SU_STEP;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_POP_TOP: begin
            if (cmp_lt) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = heap_rdata;
               rsp_exh_in   = 1'b0;
               map_we       = 1'b1;
               map_waddr    = heap_rdata[BAW-1:0];
               map_wdata    = 1'b0;
               count_in     = count_dec;
               if (count_dec == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  heap_re    = 1'b1;
                  heap_raddr = count_dec[AW-1:0];
                  state_in   = ST_POP_LAST;
               end
            end else begin
               issue_fresh = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_POP_LAST: begin
            cur_in   = heap_rdata;
            pos_in   = '0;
            state_in = ST_SD_STEP;
         end
         ST_SD_STEP: begin
            if (l_ok) begin
               heap_re    = 1'b1;
               heap_raddr = l_idx[AW-1:0];
               state_in   = ST_SD_L;
            end else begin
               heap_we  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_SD_L: begin
            bv_in   = cmp_lt ? heap_rdata : cur_ff;
            move_in = cmp_lt;
            if (r_ok) begin
               heap_re    = 1'b1;
               heap_raddr = r_idx[AW-1:0];
               state_in   = ST_SD_R;
            end else begin
               heap_we = 1'b1;
               if (cmp_lt) begin
                  heap_wdata = heap_rdata;
                  pos_in     = l_idx[AW-1:0];
                  state_in   = ST_SD_STEP;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SD_R: begin
            heap_we = 1'b1;
            if (cmp_lt) begin
               heap_wdata = heap_rdata;
               pos_in     = r_idx[AW-1:0];
               state_in   = ST_SD_STEP;
            end else if (move_ff) begin
               heap_wdata = bv_ff;
               pos_in     = l_idx[AW-1:0];
               state_in   = ST_SD_STEP;
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // pop served by the fresh counter, or exhausted
      if (issue_fresh) begin
         rsp_valid_in = 1'b1;
         if (fresh_ff != FRESH_END) begin
            rsp_value_in = fresh_ff;
            rsp_exh_in   = 1'b0;
            map_we       = 1'b1;
            map_waddr    = fresh_ff[BAW-1:0];
            map_wdata    = 1'b0;
            fresh_in     = fresh_ff + VW'(1);
         end else begin
            rsp_value_in = '0;
            rsp_exh_in   = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         fresh_ff     <= VW'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      num_ff       <= num_in;
      cur_ff       <= cur_in;
      pos_ff       <= pos_in;
      bv_ff        <= bv_in;
      move_ff      <= move_in;
      rsp_value_ff <= rsp_value_in;
      rsp_exh_ff   <= rsp_exh_in;
   end

   assign busy               = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_smallest_value = rsp_value_ff;
   assign rsp_exhausted      = rsp_exh_ff;

endmodule

>>> design/sfa_checker.sv
// ----------------------------------------------------------------------------
// sfa_checker
// port-level checks of the smallest free id allocator
// ----------------------------------------------------------------------------
module sfa_checker
   import sfa_pkg::*;
#(
   parameter int MAX_VALUE = 1024
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               start,
   input logic                               busy,
   input logic                               req_cmd,
   input logic [$clog2(MAX_VALUE+2)-1:0]     req_number,
   input logic                               rsp_valid,
   input logic [$clog2(MAX_VALUE+2)-1:0]     rsp_smallest_value,
   input logic                               rsp_exhausted
);

   localparam int VW = $clog2(MAX_VALUE + 2);

   // reset leaves the block idle with nothing to report
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !busy && !rsp_valid)
      else $error("not idle after reset");

   // first pop after reset hands out number one
   a_first_pop: assert property (@(posedge clock) disable iff (reset)
      $past(reset) && start && !busy && req_cmd == CMD_POP |=>
         rsp_valid && !rsp_exhausted && rsp_smallest_value == VW'(1))
      else $error("first pop did not give one");

   // an add-back request never produces a response
   a_add_silent: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_cmd == CMD_ADD |=> !rsp_valid)
      else $error("response after add-back");

   // issued numbers stay in range, exhaustion reports zero
   a_value_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_exhausted && rsp_smallest_value == '0) ||
         (!rsp_exhausted && rsp_smallest_value != '0 &&
          rsp_smallest_value <= VW'(MAX_VALUE)))
      else $error("response value out of range");

endmodule

bind smallest_free_id_allocator sfa_checker #(.MAX_VALUE(MAX_VALUE)) u_sfa_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .req_cmd            (req_cmd),
   .req_number         (req_number),
   .rsp_valid          (rsp_valid),
   .rsp_smallest_value (rsp_smallest_value),
   .rsp_exhausted      (rsp_exhausted)
);

>>> dv/smallest_free_id_allocator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// smallest_free_id_allocator_tb
// self-checking bench for the smallest free id allocator
// ----------------------------------------------------------------------------
// pop and add-back requests go in through the start/busy handshake with random
// gaps. A bench-side model of the free pool predicts every pop response, and
// a monitor compares each strobed response against the oldest prediction. The
// run goes from directed corner cases through random churn, drains the fresh
// counter to exhaustion, then refills the heap and empties it again.
// ----------------------------------------------------------------------------
module smallest_free_id_allocator_tb;
   import sfa_pkg::*;

   localparam int MAX_ID        = 1024;
   localparam int NUM_W         = $clog2(MAX_ID + 2);
   localparam int NUM_TOP       = 2 ** NUM_W - 1;
   localparam int STALL_LIMIT   = 1000;  // cycles with no request or response taken
   localparam int SETTLE_CYCLES = 48;    // settle time, longer than the longest sift down

   // one predicted pop response
   typedef struct packed {
      logic [NUM_W-1:0] smallest_value;
      logic             exhausted;
   } id_grant_type;

   logic             clock;
   logic             reset      = 1'b1;
   logic             start      = 1'b0;
   logic             req_cmd    = CMD_POP;
   logic [NUM_W-1:0] req_number = '0;
   logic             busy;
   logic             rsp_valid;
   logic [NUM_W-1:0] rsp_smallest_value;
   logic             rsp_exhausted;

   smallest_free_id_allocator #(
      .MAX_VALUE (MAX_ID)
   ) uut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_cmd            (req_cmd),
      .req_number         (req_number),
      .rsp_valid          (rsp_valid),
      .rsp_smallest_value (rsp_smallest_value),
      .rsp_exhausted      (rsp_exhausted)
   );

   // bench copy of the allocator state: which issued numbers sit in the free
   // heap, and the next number never handed out
   bit [MAX_ID:0] returned_pool;
   int unsigned   pool_size  = 0;
   int unsigned   fresh_next = 1;

   id_grant_type  due_grants[$];   // pop responses still to arrive, oldest first
   id_grant_type  head_grant;
   bit            failed      = 1'b0;
   int            stall_count = 0;
   int            calm_left   = 0;   // requests left in the current no-gap stretch

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // prediction
   // ---------------------------------------------------------------------------

   // update the pool for one accepted request and queue the pop response
   task automatic predict_allocation(input logic cmd, input logic [NUM_W-1:0] number);
      id_grant_type grant;
      int unsigned  lowest;
      if (cmd == CMD_ADD) begin
         // only numbers already issued and not already free go back in
         if (number >= 1 && number <= MAX_ID && number < fresh_next &&
             !returned_pool[number] && pool_size < MAX_ID) begin
            returned_pool[number] = 1'b1;
            pool_size++;
         end
      end else begin
         lowest = 0;
         for (int v = 1; v <= MAX_ID && lowest == 0; v++)
            if (returned_pool[v]) lowest = v;
         grant = '0;
         if (pool_size > 0 && lowest < fresh_next) begin
            // heap minimum wins over the fresh counter
            grant.smallest_value = lowest[NUM_W-1:0];
            returned_pool[lowest] = 1'b0;
            pool_size--;
         end else if (fresh_next <= MAX_ID) begin
            grant.smallest_value = fresh_next[NUM_W-1:0];
            fresh_next++;
         end else begin
            // nothing left: value 0 with the exhausted flag, no state change
            grant.exhausted = 1'b1;
         end
         due_grants.push_back(grant);
      end
   endtask

   // ---------------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------------

   // idle cycles before the next request; now and then a stretch of none
   function automatic int next_gap();
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm_left = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 18);
   endfunction

   // a number that was issued and is not free yet, 0 if there is none
   function automatic logic [NUM_W-1:0] pick_issued();
      int unsigned cand;
      if (fresh_next <= 1) return '0;
      for (int t = 0; t < 16; t++) begin
         cand = $urandom_range(1, fresh_next - 1);
         if (!returned_pool[cand]) return cand[NUM_W-1:0];
      end
      for (int v = 1; v < fresh_next; v++)
         if (!returned_pool[v]) return v[NUM_W-1:0];
      return '0;
   endfunction

   // an add-back the block must ignore, or an issued number that may be a repeat
   function automatic logic [NUM_W-1:0] pick_stray();
      int unsigned cand;
      case ($urandom_range(0, 3))
         0: cand = 0;
         1: cand = $urandom_range(MAX_ID + 1, NUM_TOP);
         2: cand = (fresh_next <= MAX_ID) ? $urandom_range(fresh_next, MAX_ID) : NUM_TOP;
         default: cand = (fresh_next > 1) ? $urandom_range(1, fresh_next - 1) : 0;
      endcase
      return cand[NUM_W-1:0];
   endfunction

   // drive one request and hold it until the block takes it
   task automatic send_request(input logic cmd, input logic [NUM_W-1:0] number);
      int gap;
      gap = next_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start      <= 1'b1;
      req_cmd    <= cmd;
      req_number <= number;
      // busy here is the value before this edge, so a low one means taken
      do @(posedge clock); while (busy);
      predict_allocation(cmd, number);
   endtask

   // the number field is a don't-care on a pop, so it gets noise
   task automatic send_pop();
      send_request(CMD_POP, NUM_W'($urandom_range(0, NUM_TOP)));
   endtask

   // ---------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------

   // first fresh numbers, every ignored add-back flavour, heap minimum first
   task automatic test_directed();
      repeat (4) send_pop();
      send_request(CMD_ADD, NUM_W'(3));            // well-formed return
      send_request(CMD_ADD, NUM_W'(3));            // repeat of a free number
      send_request(CMD_ADD, NUM_W'(5));            // not issued yet
      send_request(CMD_ADD, NUM_W'(0));            // below range
      send_request(CMD_ADD, NUM_W'(MAX_ID + 1));   // above range
      send_request(CMD_ADD, NUM_TOP[NUM_W-1:0]);   // all ones
      send_request(CMD_ADD, NUM_W'(MAX_ID));       // top of range, never issued
      send_pop();                                  // heap gives 3
      send_pop();                                  // counter gives 5
      send_request(CMD_ADD, NUM_W'(1));
      send_request(CMD_ADD, NUM_W'(4));
      send_request(CMD_ADD, NUM_W'(2));
      repeat (4) send_pop();                       // 1, 2, 4 from the heap, then 6
   endtask

   // mixed pops and returns keep the heap a few levels deep
   task automatic test_random_churn(input int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < 55)
            send_pop();
         else if ($urandom_range(0, 4) != 0)
            send_request(CMD_ADD, pick_issued());
         else
            send_request(CMD_ADD, pick_stray());
      end
   endtask

   // run the fresh counter out, then poke the exhausted state
   task automatic test_run_to_exhaustion();
      while (fresh_next <= MAX_ID) begin
         if ($urandom_range(0, 49) == 0)
            send_request(CMD_ADD, pick_issued());
         else
            send_pop();
      end
      while (pool_size > 0) send_pop();
      repeat (4) send_pop();
   endtask

   // with every number issued, fill a deep heap and pop it dry again
   task automatic test_refill_after_exhaustion(input int count);
      send_request(CMD_ADD, NUM_W'(MAX_ID));
      send_request(CMD_ADD, NUM_W'(1));
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 5) != 0)
            send_request(CMD_ADD, pick_issued());
         else
            send_request(CMD_ADD, pick_stray());
      end
      repeat (pool_size + 3) send_pop();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_churn(60);
      test_run_to_exhaustion();
      test_refill_after_exhaustion(30);

      start <= 1'b0;
      while (due_grants.size() != 0) @(posedge clock);
      // an add-back may still be sifting, give it time to finish
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (!failed)
         $display("smallest_free_id_allocator: match");
      else
         $display("smallest_free_id_allocator: mismatch");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // response check
   // ---------------------------------------------------------------------------

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         if (due_grants.size() == 0) begin
            $error("response with no pop outstanding: smallest_value %0d exhausted %0b",
                   rsp_smallest_value, rsp_exhausted);
            failed = 1'b1;
         end else begin
            head_grant = due_grants.pop_front();
            if (rsp_smallest_value !== head_grant.smallest_value) begin
               $error("smallest_value: expected %0d, got %0d",
                      head_grant.smallest_value, rsp_smallest_value);
               failed = 1'b1;
            end
            if (rsp_exhausted !== head_grant.exhausted) begin
               $error("exhausted: expected %0b, got %0b",
                      head_grant.exhausted, rsp_exhausted);
               failed = 1'b1;
            end
         end
      end
   end

   // watchdog: too long with neither a request nor a response taken
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid === 1'b1) begin
         stall_count <= 0;
      end else if (stall_count >= STALL_LIMIT) begin
         $display("smallest_free_id_allocator: mismatch");
         $finish;
      end else begin
         stall_count <= stall_count + 1;
      end
   end

endmodule

>>> filelist.f
design/sfa_pkg.sv
design/sfa_ram.sv
design/smallest_free_id_allocator.sv
design/sfa_checker.sv
dv/smallest_free_id_allocator_tb.sv
